@@ rtl/ckhi_pkg.sv @@
// Shared types and constants for the coordinate key hash index block.
// Holds the item structs, the opcode and register index codes, and the
// hash constants. No dependencies.
package ckhi_pkg;

  // Pipeline depth, counting the entry register and the output register.
  localparam int unsigned NumStages = 8;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned HashW = 32;

  // Hash mixing constants.
  localparam logic [HashW-1:0] MmC1 = 32'hcc9e2d51;
  localparam logic [HashW-1:0] MmC2 = 32'h1b873593;
  localparam logic [HashW-1:0] MmN  = 32'he6546b64;
  localparam logic [HashW-1:0] MmF1 = 32'h85ebca6b;
  localparam logic [HashW-1:0] MmF2 = 32'hc2b2ae35;

  // Key length in bytes, folded in at finalization.
  localparam logic [HashW-1:0] KeyBytes = 32'd8;

  // Key forms. Codes above the last member select the raw key.
  typedef enum logic [2:0] {
    OP_RAW       = 3'd0,
    OP_XY        = 3'd1,
    OP_XY_LABEL  = 3'd2,
    OP_XYZ       = 3'd3,
    OP_XYZ_LABEL = 3'd4
  } op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_HASH_SEED  = 1'b0,
    CFG_TABLE_ROWS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [KeyW-1:0] raw_key;
    logic [15:0]     coord_x;
    logic [15:0]     coord_y;
    logic [10:0]     coord_z;
    logic [30:0]     region_label;
  } in_item_t;

  typedef struct packed {
    logic [HashW-1:0] bucket_index;
    logic [KeyW-1:0]  packed_key;
  } out_item_t;

endpackage

@@ rtl/ckhi_hash_pipe.sv @@
// Eight-stage hash pipeline: block mixing, finalization and bucket masking.
// Depends on ckhi_pkg for constants and the result item struct.
module ckhi_hash_pipe import ckhi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 valid_i,
  input  logic [KeyW-1:0]      key_i,
  input  logic [HashW-1:0]     seed_i,
  input  logic [HashW-1:0]     mask_i,
  output logic [NumStages-1:0] valid_vec_o,
  output out_item_t            out_item_o
);

  // Rotation by a constant amount; pure wiring.
  function automatic logic [HashW-1:0] rotl32(logic [HashW-1:0] v, int unsigned r);
    rotl32 = (v << r) | (v >> (HashW - r));
  endfunction

  logic [NumStages-1:0] vld_q;
  logic [KeyW-1:0]      key_q [NumStages-1];

  logic [HashW-1:0] s1_k0_d, s1_k1_d, s1_k0_q, s1_k1_q;
  logic [HashW-1:0] s2_k0_d, s2_k1_d, s2_k0_q, s2_k1_q;
  logic [HashW-1:0] s3_h_d, s3_h_q, s3_k1_q;
  logic [HashW-1:0] s4_h_d, s4_h_q;
  logic [HashW-1:0] s5_h_d, s5_h_q;
  logic [HashW-1:0] s6_h_d, s6_h_q;
  out_item_t        out_d, out_q;

  logic [HashW-1:0] s3_rot, s4_rot, s4_mix, s4_len, s6_fold, s7_fold;

  // Valid bits move with the data and hold while the pipeline is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance_i) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  // Block mixing, then finalization, one short step per stage.
  always_comb begin
    // Stage 1: first multiply of both key words.
    s1_k0_d = key_q[0][HashW-1:0] * MmC1;
    s1_k1_d = key_q[0][KeyW-1:HashW] * MmC1;
    // Stage 2: rotate and second multiply.
    s2_k0_d = rotl32(s1_k0_q, 15) * MmC2;
    s2_k1_d = rotl32(s1_k1_q, 15) * MmC2;
    // Stage 3: fold the low word into the seed.
    s3_rot  = rotl32(seed_i ^ s2_k0_q, 13);
    s3_h_d  = (s3_rot << 2) + s3_rot + MmN;
    // Stage 4: fold the high word, add the length, first shift-xor.
    s4_rot  = rotl32(s3_h_q ^ s3_k1_q, 13);
    s4_mix  = (s4_rot << 2) + s4_rot + MmN;
    s4_len  = s4_mix ^ KeyBytes;
    s4_h_d  = s4_len ^ (s4_len >> 16);
    // Stage 5: first finalization multiply.
    s5_h_d  = s4_h_q * MmF1;
    // Stage 6: shift-xor and second finalization multiply.
    s6_fold = s5_h_q ^ (s5_h_q >> 13);
    s6_h_d  = s6_fold * MmF2;
    // Stage 7: last shift-xor and the bucket mask.
    s7_fold = s6_h_q ^ (s6_h_q >> 16);
    out_d.bucket_index = s7_fold & mask_i;
    out_d.packed_key   = key_q[NumStages-2];
  end

  // Payload registers; every stage loads together when the pipeline moves.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      key_q[0] <= key_i;
      for (int i = 1; i < NumStages - 1; i++) begin
        key_q[i] <= key_q[i-1];
      end
      s1_k0_q <= s1_k0_d;
      s1_k1_q <= s1_k1_d;
      s2_k0_q <= s2_k0_d;
      s2_k1_q <= s2_k1_d;
      s3_h_q  <= s3_h_d;
      s3_k1_q <= s2_k1_q;
      s4_h_q  <= s4_h_d;
      s5_h_q  <= s5_h_d;
      s6_h_q  <= s6_h_d;
      out_q   <= out_d;
    end
  end

  assign valid_vec_o = vld_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/coordinate_key_hash_index.sv @@
// Top level of the coordinate key hash index block: key packing,
// configuration registers and pipeline handshake.
// Depends on ckhi_pkg and ckhi_hash_pipe.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one item per
//   accepted cycle. The opcode picks the key form (raw, xy, xy with label,
//   xyz, xyz with label); the packed 64-bit key is hashed with 32-bit
//   Murmur3 using the seed register and masked with table rows minus one.
//   Output channel out_valid_o / out_stall_i / out_item_o returns the bucket
//   index together with the packed key, one result per item, in order.
//   Throughput is one item per cycle while the output is not stalled; the
//   pipeline has eight register stages. The two 32-bit multipliers in each
//   of stages one and two, and the single one in each of stages five and
//   six, set the stage depth.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and sets both configuration registers to
//   zero; a zero row count gives a mask of all ones. Write configuration
//   through cfg_we_i / cfg_index_i / cfg_wdata_i only while the block is
//   idle.
module coordinate_key_hash_index import ckhi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [HashW-1:0] cfg_wdata_i
);

  logic [HashW-1:0]     hash_seed_q, table_rows_q;
  logic [HashW-1:0]     row_mask;
  logic [KeyW-1:0]      key_d;
  logic                 advance;
  logic [NumStages-1:0] valid_vec;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q  <= '0;
      table_rows_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HASH_SEED:  hash_seed_q  <= cfg_wdata_i;
        CFG_TABLE_ROWS: table_rows_q <= cfg_wdata_i;
      endcase
    end
  end

  assign row_mask = table_rows_q - 32'd1;

  // Key packing; the 3D forms OR their fields without masking, the 2D forms concatenate them.
  always_comb begin
    case (in_item_i.opcode)
      OP_XY: begin
        key_d = {32'd0, in_item_i.coord_y, in_item_i.coord_x};
      end
      OP_XY_LABEL: begin
        key_d = {1'b0, in_item_i.region_label, in_item_i.coord_y, in_item_i.coord_x};
      end
      OP_XYZ: begin
        key_d = (KeyW'(in_item_i.coord_z) << 22) | (KeyW'(in_item_i.coord_y) << 11)
              | KeyW'(in_item_i.coord_x);
      end
      OP_XYZ_LABEL: begin
        key_d = (KeyW'(in_item_i.region_label) << 33) | (KeyW'(in_item_i.coord_z) << 22)
              | (KeyW'(in_item_i.coord_y) << 11) | KeyW'(in_item_i.coord_x);
      end
      default: begin
        key_d = in_item_i.raw_key;
      end
    endcase
  end

  // The pipeline moves unless a finished result is held by the receiver.
  assign advance     = !(valid_vec[NumStages-1] && out_stall_i);
  assign in_stall_o  = !advance;
  assign out_valid_o = valid_vec[NumStages-1];

  ckhi_hash_pipe u_hash_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .valid_i     (in_valid_i),
    .key_i       (key_d),
    .seed_i      (hash_seed_q),
    .mask_i      (row_mask),
    .valid_vec_o (valid_vec),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // An accepted item always lands in the entry stage.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_vec[0])
    else $error("accepted item did not enter the pipeline");

  // A stall freezes the occupancy of every stage.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(valid_vec))
    else $error("pipeline occupancy changed during a stall");

  // When the pipeline moves, the output stage takes what stood before it.
  a_output_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> valid_vec[NumStages-1] == $past(valid_vec[NumStages-2]))
    else $error("output stage valid did not follow its predecessor");
`endif

endmodule

@@ test/ckhi_bucket_checker.sv @@
`timescale 1ns / 1ps
// Checker for the coordinate key hash index block: tracks register writes,
// predicts the bucket and packed key of every accepted item and compares
// them with the results in order. Depends on ckhi_pkg.
module ckhi_bucket_checker import ckhi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_item_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [HashW-1:0] cfg_wdata_i,
  output int unsigned      error_count_o,
  output int unsigned      outstanding_o
);

  // Local copy of the two configuration registers.
  logic [HashW-1:0] seed_q;
  logic [HashW-1:0] rows_q;

  // Buckets and keys predicted for items accepted but not yet returned.
  out_item_t bucket_queue[$];

  function automatic logic [HashW-1:0] rotate_left(input logic [HashW-1:0] v,
                                                   input int unsigned      r);
    return (v << r) | (v >> (HashW - r));
  endfunction

  // One Murmur3 block step: scramble the key word, fold it into the state.
  function automatic logic [HashW-1:0] mix_word(input logic [HashW-1:0] h,
                                                input logic [HashW-1:0] k);
    logic [HashW-1:0] kk;
    logic [HashW-1:0] hh;
    kk = k * MmC1;
    kk = rotate_left(kk, 15);
    kk = kk * MmC2;
    hh = rotate_left(h ^ kk, 13);
    return hh * 32'd5 + MmN;
  endfunction

  // Builds the 64-bit key; the fields are ORed without any masking, so in
  // the 3D forms wide X and Y values spill into the next field.
  function automatic logic [KeyW-1:0] form_key(input in_item_t it);
    logic [KeyW-1:0] x;
    logic [KeyW-1:0] y;
    logic [KeyW-1:0] z;
    logic [KeyW-1:0] lab;
    x   = KeyW'(it.coord_x);
    y   = KeyW'(it.coord_y);
    z   = KeyW'(it.coord_z);
    lab = KeyW'(it.region_label);
    case (it.opcode)
      OP_XY:        return (y << 16) | x;
      OP_XY_LABEL:  return (lab << 32) | (y << 16) | x;
      OP_XYZ:       return (z << 22) | (y << 11) | x;
      OP_XYZ_LABEL: return (((lab << 11) | z) << 22) | (y << 11) | x;
      default:      return it.raw_key;
    endcase
  endfunction

  // Hashes the key as two words, low word first, and masks the result.
  function automatic out_item_t predict_bucket(input in_item_t         it,
                                               input logic [HashW-1:0] seed,
                                               input logic [HashW-1:0] rows);
    out_item_t        res;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] h;
    logic [HashW-1:0] mask;
    key = form_key(it);
    h = mix_word(seed, key[31:0]);
    h = mix_word(h, key[63:32]);
    h = h ^ KeyBytes;
    h = h ^ (h >> 16);
    h = h * MmF1;
    h = h ^ (h >> 13);
    h = h * MmF2;
    h = h ^ (h >> 16);
    // A zero row count wraps to a mask of all ones.
    mask = rows - 32'd1;
    res.bucket_index = h & mask;
    res.packed_key   = key;
    return res;
  endfunction

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    out_item_t want;
    if (!rst_ni) begin
      seed_q = '0;
      rows_q = '0;
      bucket_queue.delete();
      error_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HASH_SEED:  seed_q = cfg_wdata_i;
          CFG_TABLE_ROWS: rows_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (bucket_queue.size() == 0) begin
          $error("unexpected result: bucket_index %h, packed_key %h",
                 out_item_i.bucket_index, out_item_i.packed_key);
          error_count_o++;
        end else begin
          want = bucket_queue.pop_front();
          if (out_item_i.bucket_index !== want.bucket_index) begin
            $error("bucket_index mismatch: expected %h, actual %h",
                   want.bucket_index, out_item_i.bucket_index);
            error_count_o++;
          end
          if (out_item_i.packed_key !== want.packed_key) begin
            $error("packed_key mismatch: expected %h, actual %h",
                   want.packed_key, out_item_i.packed_key);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        bucket_queue.push_back(predict_bucket(in_item_i, seed_q, rows_q));
      end
      outstanding_o = bucket_queue.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the coordinate key hash index block: clock, reset,
// register settings, item stimulus and receiver stalls, and the verdict.
// Depends on ckhi_pkg, coordinate_key_hash_index and ckhi_bucket_checker.
module tb;
  import ckhi_pkg::*;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 215;
  localparam int unsigned PressurePhase = 3;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned IdleLimit     = 20000;
  localparam logic [2:0]  OpSpareLo     = 3'(OP_XYZ_LABEL) + 3'd1;
  localparam logic [2:0]  OpTop         = '1;

  logic             clk_i = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [HashW-1:0] cfg_wdata;
  int unsigned      error_count;
  int unsigned      outstanding;
  logic             hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  coordinate_key_hash_index uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  ckhi_bucket_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  function automatic in_item_t make_item(input logic [2:0]  op,
                                         input logic [63:0] raw,
                                         input logic [15:0] x,
                                         input logic [15:0] y,
                                         input logic [10:0] z,
                                         input logic [30:0] lab);
    in_item_t it;
    it.opcode       = op;
    it.raw_key      = raw;
    it.coord_x      = x;
    it.coord_y      = y;
    it.coord_z      = z;
    it.region_label = lab;
    return it;
  endfunction

  // Random value up to a mask, with zero and the maximum favored.
  function automatic logic [63:0] pick_value(input logic [63:0] maxv);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return maxv;
      default: return {$urandom, $urandom} & maxv;
    endcase
  endfunction

  // Mostly the five key forms, now and then one of the spare opcodes.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 17) begin
      it.opcode = 3'(r % (int'(OP_XYZ_LABEL) + 1));
    end else begin
      it.opcode = 3'($urandom_range(OpSpareLo, OpTop));
    end
    it.raw_key      = pick_value('1);
    it.coord_x      = 16'(pick_value(64'hffff));
    it.coord_y      = 16'(pick_value(64'hffff));
    it.coord_z      = 11'(pick_value(64'h7ff));
    it.region_label = 31'(pick_value(64'h7fffffff));
    return it;
  endfunction

  // Mostly back to back, often short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 8);
    else return $urandom_range(15, 40);
  endfunction

  // Offers one item and returns at the edge that accepts it.
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Keeps the input idle for the given number of cycles.
  task automatic pause(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic set_registers(input logic [HashW-1:0] seed,
                               input logic [HashW-1:0] rows);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HASH_SEED;
    cfg_wdata <= seed;
    @(negedge clk_i);
    cfg_index <= CFG_TABLE_ROWS;
    cfg_wdata <= rows;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Waits, with a limit, until every predicted result has come back.
  task automatic wait_idle();
    for (int n = 0; n < IdleLimit && outstanding != 0; n++) @(negedge clk_i);
  endtask

  // Field extremes, every key form, the overlapping 3D packings and the
  // spare opcodes.
  task automatic run_directed();
    send_item(make_item(OP_RAW, '0, '0, '0, '0, '0));
    send_item(make_item(OP_RAW, '1, '1, '1, '1, '1));
    send_item(make_item(OP_RAW, 64'h0123456789abcdef, '0, '0, '0, '0));
    send_item(make_item(OP_XY, '0, '0, '0, '0, '0));
    send_item(make_item(OP_XY, '0, '1, '1, '0, '0));
    // Fields the form does not use are ignored.
    send_item(make_item(OP_XY, '1, 16'h1234, 16'h8001, '1, '1));
    send_item(make_item(OP_XY_LABEL, '0, '1, '1, '0, '1));
    send_item(make_item(OP_XY_LABEL, '1, 16'h0001, 16'h0001, '1, '0));
    send_item(make_item(OP_XYZ, '0, '0, '0, '0, '0));
    send_item(make_item(OP_XYZ, '0, 16'h07ff, 16'h07ff, 11'h3ff, '0));
    // X above bit 10 runs into Y, Y above bit 10 runs into Z.
    send_item(make_item(OP_XYZ, '0, '1, '1, '1, '1));
    send_item(make_item(OP_XYZ, '0, 16'h0800, 16'h0800, '0, '0));
    send_item(make_item(OP_XYZ_LABEL, '0, '1, '1, '1, '1));
    send_item(make_item(OP_XYZ_LABEL, '1, 16'h0800, '0, '0, 31'h1));
    send_item(make_item(OP_XYZ_LABEL, '0, '0, 16'hf800, '0, 31'h40000000));
    for (int o = OpSpareLo; o <= OpTop; o++) begin
      send_item(make_item(3'(o), {$urandom, $urandom}, 16'($urandom),
                          16'($urandom), 11'($urandom), 31'($urandom)));
    end
  endtask

  // Receiver: stall bursts at a changing rate, occasional long holds, and
  // one long hold-off on request so that the pipeline backs up.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_pct;
    int unsigned r;
    logic        hold_done;
    out_stall = 1'b0;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        r = $urandom_range(0, 99);
        if (stall_pct != 0 && r == 0) hold_left = $urandom_range(10, 30);
        out_stall <= (r < stall_pct);
      end
    end
  end

  // Stimulus: one register setting per phase, directed items in the first
  // phase only, then random items with bursts that have no gaps.
  initial begin : stimulus
    logic [HashW-1:0] seeds [NumPhases];
    logic [HashW-1:0] rows [NumPhases];
    int unsigned      gap;
    logic             gaps_on;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_HASH_SEED;
    cfg_wdata = '0;
    gaps_on   = 1'b1;

    // Zero rows, all ones, a single row, a power of two, an odd count and
    // the top bit alone.
    seeds[0] = '0;        rows[0] = '0;
    seeds[1] = '1;        rows[1] = '1;
    seeds[2] = $urandom;  rows[2] = 32'd1;
    seeds[3] = $urandom;  rows[3] = 32'h0001_0000;
    seeds[4] = $urandom;  rows[4] = 32'($urandom_range(2, 100000)) | 32'd3;
    seeds[5] = 32'h9747b28c; rows[5] = 32'h8000_0000;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      set_registers(seeds[p], rows[p]);
      if (p == 0) run_directed();
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        send_item(random_item());
        if (p == PressurePhase && i == 0) hold_req = 1'b1;
        // Keep offering items while the receiver holds off.
        if (p == PressurePhase && i < 60) gap = 0;
        else gap = gaps_on ? pick_gap() : 0;
        pause(gap);
      end
      pause(1);
      wait_idle();
    end

    repeat (NumStages + 4) @(negedge clk_i);
    if (error_count == 0 && outstanding == 0) begin
      $display("PASS coordinate_key_hash_index");
    end else begin
      $display("FAIL coordinate_key_hash_index");
    end
    $finish;
  end

  // Hard limit on the length of the run.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL coordinate_key_hash_index");
    $finish;
  end

endmodule
